// File: src/apd_pkg.sv
// ---------------------------------------------------------------------------
// apd_pkg
// Shared types, constants and helpers for the converter peak detector buffer.
// ---------------------------------------------------------------------------
package apd_pkg;

    localparam int RING_DEPTH = 8;
    localparam int PTR_W      = $clog2(RING_DEPTH);
    localparam int VALUE_W    = 10;
    localparam int COUNT_W    = 32;
    localparam int DECIM_W    = 5;
    localparam int ADDR_W     = 4;
    localparam int DATA_W     = 32;

    localparam logic [DECIM_W-1:0] DECIM_RESET  = DECIM_W'(12);
    localparam logic [VALUE_W-1:0] THRESH_RESET = VALUE_W'(15);

    typedef logic [PTR_W-1:0]   ptr_t;
    typedef logic [VALUE_W-1:0] value_t;
    typedef logic [COUNT_W-1:0] count_t;

    typedef enum logic [1:0] {
        REG_PEAK_MODE    = 2'd0,
        REG_DECIM_LOG2   = 2'd1,
        REG_FALL_THRESH  = 2'd2,
        REG_RISE_THRESH  = 2'd3
    } reg_idx_t;

    // one buffered entry: value and the sample count that goes with it
    typedef struct packed {
        value_t value;
        count_t count;
    } entry_t;

    typedef struct packed {
        logic push;
        logic pop;
    } ring_ctl_t;

    typedef struct packed {
        logic empty;
        logic full;
    } ring_stat_t;

    function automatic ptr_t ptr_inc(input ptr_t p);
        return (p == PTR_W'(RING_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

endpackage

// File: src/apd_if.sv
// ---------------------------------------------------------------------------
// apd_if
// Valid/ready channels for items into and results out of the peak detector.
// ---------------------------------------------------------------------------
interface apd_item_if;
    import apd_pkg::*;

    logic   valid;
    logic   ready;
    logic   func;
    value_t sample;

    modport source (output valid, output func, output sample, input ready);
    modport sink   (input valid, input func, input sample, output ready);
endinterface

interface apd_result_if;
    import apd_pkg::*;

    logic   valid;
    logic   ready;
    logic   read_valid;
    value_t read_value;
    count_t read_count;
    logic   pushed;
    logic   dropped;

    modport source (output valid, output read_valid, output read_value,
                    output read_count, output pushed, output dropped, input ready);
    modport sink   (input valid, input read_valid, input read_value,
                    input read_count, input pushed, input dropped, output ready);
endinterface

// File: src/adc_peak_detector_fifo.sv
// ---------------------------------------------------------------------------
// adc_peak_detector_fifo
// Sample counter with decimating sampler or peak detector, feeding a ring buffer.
// ---------------------------------------------------------------------------
// Result path: each item is registered in the ring read stage, then in the
//   output register.
// Throughput: one item per cycle while the result side takes results; each item makes at most one ring access.
// Reset: rst_n clears counters, detector, pointers and registers to defaults;
//   ring contents are not cleared, entries are only read after being written.
module adc_peak_detector_fifo (
    input  logic                         clk,
    input  logic                         rst_n,
    apd_item_if.sink                     item,
    apd_result_if.source                 result,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [apd_pkg::ADDR_W-1:0]   paddr,
    input  logic [apd_pkg::DATA_W-1:0]   pwdata,
    output logic [apd_pkg::DATA_W-1:0]   prdata,
    output logic                         pready
);
    import apd_pkg::*;

    // configuration
    logic                peak_mode_reg;
    logic [DECIM_W-1:0]  decim_log2_reg;
    value_t              fall_thresh_reg;
    value_t              rise_thresh_reg;

    // detector state
    count_t sample_count_reg;
    logic   hunt_min_reg;
    value_t max_value_reg;
    count_t max_count_reg;
    value_t min_value_reg;
    count_t min_count_reg;

    // pipeline
    logic   s1_valid_reg, s1_rd_valid_reg, s1_pushed_reg, s1_dropped_reg;
    logic   out_valid_reg, out_rd_valid_reg, out_pushed_reg, out_dropped_reg;
    value_t out_value_reg;
    count_t out_count_reg;

    logic       cfg_wr;
    reg_idx_t   cfg_idx;
    logic       accept, is_sample, s1_advance;
    count_t     count_next;
    count_t     decim_mask;
    logic signed [VALUE_W:0] fall_diff, rise_diff;
    logic       fall_fire, rise_fire;
    logic       want_push;
    ring_ctl_t  ring_ctl;
    ring_stat_t ring_stat;
    entry_t     wr_entry, rd_entry;

    // ---------------- configuration port ----------------
    assign pready  = 1'b1;
    assign cfg_idx = reg_idx_t'(paddr[3:2]);
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_comb
    begin
        unique case (cfg_idx)
            REG_PEAK_MODE:   prdata = DATA_W'(peak_mode_reg);
            REG_DECIM_LOG2:  prdata = DATA_W'(decim_log2_reg);
            REG_FALL_THRESH: prdata = DATA_W'(fall_thresh_reg);
            REG_RISE_THRESH: prdata = DATA_W'(rise_thresh_reg);
            default:         prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            peak_mode_reg   <= 1'b0;
            decim_log2_reg  <= DECIM_RESET;
            fall_thresh_reg <= THRESH_RESET;
            rise_thresh_reg <= THRESH_RESET;
        end
        else if (cfg_wr)
        begin
            unique case (cfg_idx)
                REG_PEAK_MODE:   peak_mode_reg   <= pwdata[0];
                REG_DECIM_LOG2:  decim_log2_reg  <= pwdata[DECIM_W-1:0];
                REG_FALL_THRESH: fall_thresh_reg <= pwdata[VALUE_W-1:0];
                REG_RISE_THRESH: rise_thresh_reg <= pwdata[VALUE_W-1:0];
                default: ;
            endcase
        end
    end

    // ---------------- handshake ----------------
    assign s1_advance = s1_valid_reg && (!out_valid_reg || result.ready);
    assign item.ready = !s1_valid_reg || !out_valid_reg || result.ready;
    assign accept     = item.valid && item.ready;
    assign is_sample  = accept && !item.func;

    // ---------------- detector ----------------
    assign count_next = sample_count_reg + 1'b1;
    assign decim_mask = (COUNT_W'(1) << decim_log2_reg) - 1'b1;

    // signed differences of the 10-bit values, strict compare against threshold
    assign fall_diff = $signed({1'b0, max_value_reg}) - $signed({1'b0, item.sample});
    assign rise_diff = $signed({1'b0, item.sample}) - $signed({1'b0, min_value_reg});
    assign fall_fire = fall_diff > $signed({1'b0, fall_thresh_reg});
    assign rise_fire = rise_diff > $signed({1'b0, rise_thresh_reg});

    always_comb
    begin
        if (!peak_mode_reg)
        begin
            want_push      = ((count_next & decim_mask) == '0);
            wr_entry.value = item.sample;
            wr_entry.count = count_next;
        end
        else
        begin
            want_push      = !hunt_min_reg && fall_fire;
            wr_entry.value = max_value_reg;
            wr_entry.count = max_count_reg;
        end
    end

    assign ring_ctl.push = is_sample && want_push && !ring_stat.full;
    assign ring_ctl.pop  = accept && item.func && !ring_stat.empty;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_count_reg <= '0;
            hunt_min_reg     <= 1'b0;
            max_value_reg    <= '0;
            max_count_reg    <= '0;
            min_value_reg    <= '0;
            min_count_reg    <= '0;
        end
        else if (is_sample)
        begin
            sample_count_reg <= count_next;
            if (peak_mode_reg)
            begin
                if (!hunt_min_reg)
                begin
                    if (fall_fire)
                    begin
                        hunt_min_reg  <= 1'b1;
                        min_value_reg <= item.sample;
                        min_count_reg <= count_next;
                    end
                    else if (item.sample > max_value_reg)
                    begin
                        max_value_reg <= item.sample;
                        max_count_reg <= count_next;
                    end
                end
                else
                begin
                    if (rise_fire)
                    begin
                        hunt_min_reg  <= 1'b0;
                        max_value_reg <= item.sample;
                        max_count_reg <= count_next;
                    end
                    else if (item.sample < min_value_reg)
                    begin
                        min_value_reg <= item.sample;
                        min_count_reg <= count_next;
                    end
                end
            end
        end
    end

    apd_ring u_ring (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (ring_ctl),
        .wr_entry (wr_entry),
        .stat     (ring_stat),
        .rd_entry (rd_entry)
    );

    // ---------------- result pipeline ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
                s1_valid_reg <= 1'b1;
            else if (s1_advance)
                s1_valid_reg <= 1'b0;

            if (s1_advance)
                out_valid_reg <= 1'b1;
            else if (result.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_rd_valid_reg <= ring_ctl.pop;
            s1_pushed_reg   <= ring_ctl.push;
            s1_dropped_reg  <= is_sample && want_push && ring_stat.full;
        end
        if (s1_advance)
        begin
            out_rd_valid_reg <= s1_rd_valid_reg;
            out_pushed_reg   <= s1_pushed_reg;
            out_dropped_reg  <= s1_dropped_reg;
            out_value_reg    <= s1_rd_valid_reg ? rd_entry.value : '0;
            out_count_reg    <= s1_rd_valid_reg ? rd_entry.count : '0;
        end
    end

    assign result.valid      = out_valid_reg;
    assign result.read_valid = out_rd_valid_reg;
    assign result.read_value = out_value_reg;
    assign result.read_count = out_count_reg;
    assign result.pushed     = out_pushed_reg;
    assign result.dropped    = out_dropped_reg;

    // ---------------- assertions ----------------
    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        !item.ready |-> (s1_valid_reg && out_valid_reg && !result.ready))
        else $error("input stalled while pipeline has room");

    a_result_kinds_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |-> !(result.read_valid && (result.pushed || result.dropped))
                         && !(result.pushed && result.dropped))
        else $error("result mixes pop and sample flags");

    a_ring_not_full_and_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !(ring_stat.full && ring_stat.empty))
        else $error("ring reports full and empty together");

    a_pop_followed_by_result: assert property (@(posedge clk) disable iff (!rst_n)
        ring_ctl.pop |=> (s1_valid_reg && s1_rd_valid_reg))
        else $error("pop did not reach read stage");

endmodule

// File: src/apd_ring.sv
// ---------------------------------------------------------------------------
// apd_ring
// Ring buffer of value/count entries in a single synchronous memory.
// Holds RING_DEPTH-1 entries; read data is registered on a pop.
// ---------------------------------------------------------------------------
module apd_ring (
    input  logic               clk,
    input  logic               rst_n,
    input  apd_pkg::ring_ctl_t ctl,
    input  apd_pkg::entry_t    wr_entry,
    output apd_pkg::ring_stat_t stat,
    output apd_pkg::entry_t    rd_entry
);
    import apd_pkg::*;

    entry_t mem [RING_DEPTH];
    entry_t rd_entry_reg;
    ptr_t   rd_ptr_reg;
    ptr_t   wr_ptr_reg;

    always_comb
    begin
        stat.empty = (rd_ptr_reg == wr_ptr_reg);
        stat.full  = (ptr_inc(wr_ptr_reg) == rd_ptr_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ptr_reg <= '0;
            wr_ptr_reg <= '0;
        end
        else
        begin
            if (ctl.push)
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            if (ctl.pop)
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
        end
    end

    // push and pop never come from the same transfer, so no same-entry overlap
    always_ff @(posedge clk)
    begin
        if (ctl.push)
            mem[wr_ptr_reg] <= wr_entry;
        if (ctl.pop)
            rd_entry_reg <= mem[rd_ptr_reg];
    end

    assign rd_entry = rd_entry_reg;

endmodule
